// ===== rtl/core/md5_pkg.sv =====
package md5_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_PAD,
      ST_LEN,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic       wr_byte;
      logic [7:0] wr_data;
      logic       start;
      logic       round;
      logic       finish;
      logic       pad_step;
      logic       len_step;
      logic       reinit;
      logic       count_inc;
   } cmd_type;

   typedef struct packed {
      logic       last_round;
      logic       pad_done;
      logic       pad_full;
      logic       len_done;
      logic [5:0] offset;
   } sts_type;

   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;

   function automatic logic [31:0] sine_k(input logic [5:0] i);
      logic [31:0] k;
      case (i)
         6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
         6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
         6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
         6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
         6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] shift_amt(input logic [5:0] i);
      logic [4:0] s;
      case ({i[5:4], i[1:0]})
         4'h0: s = 5'd7;  4'h1: s = 5'd12; 4'h2: s = 5'd17; 4'h3: s = 5'd22;
         4'h4: s = 5'd5;  4'h5: s = 5'd9;  4'h6: s = 5'd14; 4'h7: s = 5'd20;
         4'h8: s = 5'd4;  4'h9: s = 5'd11; 4'ha: s = 5'd16; 4'hb: s = 5'd23;
         4'hc: s = 5'd6;  4'hd: s = 5'd10; 4'he: s = 5'd15; 4'hf: s = 5'd21;
         default: s = 5'd0;
      endcase
      return s;
   endfunction

endpackage

// ===== rtl/core/md5_ctrl.sv =====
module md5_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,
   input  logic [1:0]         req_tuser,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output md5_pkg::cmd_type   cmd,
   input  md5_pkg::sts_type   sts
);

   md5_pkg::state_type state_ff, state_in;
   logic end_ff, end_in;     // message end pending after current block
   logic len_ff, len_in;     // current compression is the length block
   logic acc;

   assign acc = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      end_in   = end_ff;
      len_in   = len_ff;
      case (state_ff)
         md5_pkg::ST_IDLE: begin
            if (acc) begin
               end_in = req_tuser[1];
               len_in = 1'b0;
               if (req_tuser[0] && sts.offset == 6'd63) begin
                  state_in = md5_pkg::ST_ROUND;
               end else if (req_tuser[1]) begin
                  state_in = md5_pkg::ST_PAD;
               end
            end
         end
         md5_pkg::ST_ROUND: begin
            if (sts.last_round) begin
               if (len_ff) begin
                  state_in = md5_pkg::ST_OUT;
               end else if (end_ff) begin
                  state_in = md5_pkg::ST_PAD;
               end else begin
                  state_in = md5_pkg::ST_IDLE;
               end
            end
         end
         md5_pkg::ST_PAD: begin
            if (sts.pad_done) begin
               if (sts.pad_full) begin
                  state_in = md5_pkg::ST_ROUND;
                  len_in   = 1'b0;
               end else begin
                  state_in = md5_pkg::ST_LEN;
               end
            end
         end
         md5_pkg::ST_LEN: begin
            if (sts.len_done) begin
               state_in = md5_pkg::ST_ROUND;
               len_in   = 1'b1;
            end
         end
         md5_pkg::ST_OUT: begin
            if (rsp_tready) begin
               state_in = md5_pkg::ST_IDLE;
               end_in   = 1'b0;
            end
         end
         default: state_in = md5_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      req_tready     = 1'b0;
      rsp_tvalid     = 1'b0;
      cmd.wr_data    = req_tdata;
      case (state_ff)
         md5_pkg::ST_IDLE: begin
            req_tready    = 1'b1;
            cmd.wr_byte   = acc && req_tuser[0];
            cmd.count_inc = acc && req_tuser[0];
            cmd.start     = acc && req_tuser[0] && sts.offset == 6'd63;
         end
         md5_pkg::ST_ROUND: begin
            cmd.round  = 1'b1;
            cmd.finish = sts.last_round;
         end
         md5_pkg::ST_PAD: begin
            cmd.pad_step = 1'b1;
            cmd.start    = sts.pad_done && sts.pad_full;
         end
         md5_pkg::ST_LEN: begin
            cmd.len_step = 1'b1;
            cmd.start    = sts.len_done;
         end
         md5_pkg::ST_OUT: begin
            rsp_tvalid = 1'b1;
            cmd.reinit = rsp_tready;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= md5_pkg::ST_IDLE;
         end_ff   <= 1'b0;
         len_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         end_ff   <= end_in;
         len_ff   <= len_in;
      end
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != md5_pkg::ST_IDLE |-> !req_tready)
      else $error("input taken while busy");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped under stall");
   a_len_to_round: assert property (@(posedge clock) disable iff (reset)
      state_ff == md5_pkg::ST_LEN && sts.len_done |=> state_ff == md5_pkg::ST_ROUND)
      else $error("length block not compressed");

endmodule

// ===== rtl/core/md5_dpath.sv =====
module md5_dpath (
   input  logic              clock,
   input  logic              reset,
   input  md5_pkg::cmd_type  cmd,
   output md5_pkg::sts_type  sts,
   output logic [127:0]      digest
);

   // Block buffer kept as 16 little-endian words, written one byte lane at a time.
   logic [31:0] buf_mem [16];
   logic [31:0] h_ff [4];
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [5:0]  rnd_ff;
   logic [63:0] count_ff;
   logic [5:0]  ptr_ff;      // padding / length write pointer
   logic        first_ff;    // first padding step writes 0x80

   logic [5:0]  offs;
   logic [5:0]  pa;          // padding write address
   logic [3:0]  g;
   logic [31:0] fv, m, t, rot;
   logic [63:0] bits;
   logic [2:0]  li;

   assign offs = count_ff[5:0];
   assign pa   = first_ff ? offs : ptr_ff;
   assign bits = {count_ff[60:0], 3'b000};
   assign li   = ptr_ff[2:0];

   always_comb begin
      case (rnd_ff[5:4])
         2'd0: begin fv = (b_ff & c_ff) | (~b_ff & d_ff); g = rnd_ff[3:0]; end
         2'd1: begin fv = (b_ff & d_ff) | (c_ff & ~d_ff);
            g = 4'(rnd_ff * 6'd5 + 6'd1); end
         2'd2: begin fv = b_ff ^ c_ff ^ d_ff; g = 4'(rnd_ff * 6'd3 + 6'd5); end
         default: begin fv = c_ff ^ (b_ff | ~d_ff); g = 4'(rnd_ff * 6'd7); end
      endcase
   end

   assign m   = buf_mem[g];
   assign t   = a_ff + fv + md5_pkg::sine_k(rnd_ff) + m;
   assign rot = (t << md5_pkg::shift_amt(rnd_ff)) |
                (t >> (6'd32 - {1'b0, md5_pkg::shift_amt(rnd_ff)}));

   // Stop padding at offset 55 (length follows) or at the block end (block full).
   assign sts.last_round = rnd_ff == 6'd63;
   assign sts.pad_done   = pa == 6'd63 || pa == 6'd55;
   assign sts.pad_full   = pa == 6'd63;
   assign sts.len_done   = ptr_ff == 6'd63;
   assign sts.offset     = offs;

   assign digest = {h_ff[3], h_ff[2], h_ff[1], h_ff[0]};

   always_ff @(posedge clock) begin
      if (cmd.wr_byte) begin
         buf_mem[offs[5:2]][{offs[1:0], 3'b000} +: 8] <= cmd.wr_data;
      end else if (cmd.pad_step) begin
         buf_mem[pa[5:2]][{pa[1:0], 3'b000} +: 8] <= first_ff ? 8'h80 : 8'h00;
      end else if (cmd.len_step) begin
         buf_mem[ptr_ff[5:2]][{ptr_ff[1:0], 3'b000} +: 8] <= bits[{li, 3'b000} +: 8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff[0]  <= md5_pkg::INIT_A;
         h_ff[1]  <= md5_pkg::INIT_B;
         h_ff[2]  <= md5_pkg::INIT_C;
         h_ff[3]  <= md5_pkg::INIT_D;
         a_ff     <= '0;
         b_ff     <= '0;
         c_ff     <= '0;
         d_ff     <= '0;
         rnd_ff   <= '0;
         count_ff <= '0;
         ptr_ff   <= '0;
         first_ff <= 1'b1;
      end else begin
         if (cmd.count_inc) count_ff <= count_ff + 64'd1;
         if (cmd.start) begin
            a_ff <= h_ff[0]; b_ff <= h_ff[1]; c_ff <= h_ff[2]; d_ff <= h_ff[3];
            rnd_ff <= '0;
         end else if (cmd.round) begin
            a_ff   <= d_ff;
            d_ff   <= c_ff;
            c_ff   <= b_ff;
            b_ff   <= b_ff + rot;
            rnd_ff <= rnd_ff + 6'd1;
         end
         if (cmd.finish) begin
            h_ff[0] <= h_ff[0] + d_ff;
            h_ff[1] <= h_ff[1] + b_ff + rot;
            h_ff[2] <= h_ff[2] + b_ff;
            h_ff[3] <= h_ff[3] + c_ff;
         end
         // padding pointer: start at current offset, wrap to zero for a second block
         if (cmd.pad_step) begin
            first_ff <= 1'b0;
            if (first_ff && offs == 6'd63) ptr_ff <= '0;
            else if (first_ff) ptr_ff <= offs + 6'd1;
            else ptr_ff <= ptr_ff + 6'd1;
         end else if (cmd.len_step) begin
            ptr_ff <= ptr_ff + 6'd1;
         end else if (!first_ff && !cmd.round && !cmd.finish) begin
            ptr_ff <= ptr_ff;
         end
         if (cmd.reinit) begin
            h_ff[0]  <= md5_pkg::INIT_A;
            h_ff[1]  <= md5_pkg::INIT_B;
            h_ff[2]  <= md5_pkg::INIT_C;
            h_ff[3]  <= md5_pkg::INIT_D;
            count_ff <= '0;
            first_ff <= 1'b1;
            ptr_ff   <= '0;
         end
      end
   end

   a_round_adv: assert property (@(posedge clock) disable iff (reset)
      cmd.round && !cmd.start |=> rnd_ff == $past(rnd_ff) + 6'd1)
      else $error("round index stuck");
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      cmd.round |=> count_ff == $past(count_ff))
      else $error("byte count moved during compression");
   a_no_wr_round: assert property (@(posedge clock) disable iff (reset)
      cmd.round |-> !cmd.wr_byte && !cmd.pad_step && !cmd.len_step)
      else $error("buffer written during compression");

endmodule

// ===== rtl/core/md5_message_digest.sv =====
// MD5 message digest engine.
// Input channel (req_): one transaction per message byte and/or end mark.
//   req_tdata carries the byte; req_tuser[0] says the byte is present and
//   req_tuser[1] closes the message.
// Result channel (rsp_): one transaction per closed message, the 16-byte
//   digest with byte 0 in rsp_tdata[7:0].
// A byte that does not fill the 64-byte block is stored and counted. A byte
//   that fills the block also starts a compression on the single shared
//   round unit (one round per cycle). An end mark pads the block one byte
//   per cycle, writes the 8 length bytes one per cycle and runs one or two
//   compressions before the digest is offered. One item is processed at
//   a time.
// Reset (synchronous, active high) loads the initial hash words and clears
//   the byte count; the block buffer is not cleared.
// A stalled receiver holds the digest on rsp_tdata with rsp_tvalid high;
//   no input is taken until the digest is delivered.
module md5_message_digest (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte
   input  logic [1:0]   req_tuser,   // byte_present, end_of_message
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata    // digest_first_half, digest_second_half
);

   md5_pkg::cmd_type cmd;
   md5_pkg::sts_type sts;

   md5_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   md5_dpath u_dpath (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .sts    (sts),
      .digest (rsp_tdata)
   );

endmodule

// ===== tb/tb_md5_message_digest.sv =====
`timescale 1ns / 100ps

module tb_md5_message_digest;

   // Input flags carried on req_tuser, lowest bit first.
   localparam int USER_BYTE = 0;
   localparam int USER_END  = 1;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;   // data_byte
   logic [1:0]   req_tuser;   // byte_present, end_of_message
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;   // digest_first_half, digest_second_half

   md5_message_digest u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // One input transaction.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_message;
   } msg_item_type;

   // Directed row: item plus an optional digest known by heart.
   typedef struct {
      msg_item_type item;
      bit           known;
      logic [127:0] digest;
   } directed_row_type;

   // Shadow digest state.
   logic [31:0] md_hash [4];
   logic [7:0]  md_block [64];
   logic [63:0] md_count;

   logic [127:0] digest_queue [$];
   int           fail_count;
   bit           stim_done;
   bit           hold_rsp;

   // Per-round constants and shifts, written out independently of the package.
   localparam logic [31:0] ROUND_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };
   localparam int ROUND_S [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                   4, 11, 16, 23, 6, 10, 15, 21};

   // Load the standard starting hash and clear the length.
   task automatic md_restart();
      md_hash[0] = 32'h67452301;
      md_hash[1] = 32'hefcdab89;
      md_hash[2] = 32'h98badcfe;
      md_hash[3] = 32'h10325476;
      md_count   = '0;
   endtask

   // Run the 64 rounds over the shadow block and fold into the hash.
   task automatic md_compress();
      logic [31:0] a, b, c, d, f, t, m;
      int          g;
      a = md_hash[0]; b = md_hash[1]; c = md_hash[2]; d = md_hash[3];
      for (int r = 0; r < 64; r++) begin
         case (r / 16)
            0: begin f = (b & c) | (~b & d); g = r; end
            1: begin f = (b & d) | (c & ~d); g = (5 * r + 1) % 16; end
            2: begin f = b ^ c ^ d;          g = (3 * r + 5) % 16; end
            default: begin f = c ^ (b | ~d); g = (7 * r) % 16; end
         endcase
         m = {md_block[4*g+3], md_block[4*g+2], md_block[4*g+1], md_block[4*g]};
         t = a + f + ROUND_K[r] + m;
         t = (t << ROUND_S[(r / 16) * 4 + r % 4]) |
             (t >> (32 - ROUND_S[(r / 16) * 4 + r % 4]));
         a = d; d = c; c = b; b = b + t;
      end
      md_hash[0] += a; md_hash[1] += b; md_hash[2] += c; md_hash[3] += d;
   endtask

   // Advance the shadow state by one accepted transaction; queue a digest on end.
   task automatic md_absorb(input msg_item_type it);
      int          off;
      logic [63:0] bits;
      if (it.byte_present) begin
         off = md_count[5:0];
         md_block[off] = it.data_byte;
         md_count++;
         if (off == 63) md_compress();
      end
      if (it.end_of_message) begin
         off = md_count[5:0];
         md_block[off] = 8'h80;
         for (int i = off + 1; i < 64; i++) md_block[i] = 8'h00;
         if (off >= 56) begin
            md_compress();
            for (int i = 0; i < 64; i++) md_block[i] = 8'h00;
         end
         bits = md_count << 3;
         for (int i = 0; i < 8; i++) md_block[56 + i] = bits[8*i +: 8];
         md_compress();
         digest_queue.push_back({md_hash[3], md_hash[2], md_hash[1], md_hash[0]});
         md_restart();
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("tb_md5_message_digest failed");
      $finish;
   end

   // Drive one transaction, after a random gap if pause is set; hold until accepted.
   task automatic send_item(input msg_item_type it, input bit pause);
      int gap;
      gap = pause ? $urandom_range(0, 11) : 0;
      repeat (gap) @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = it.data_byte;
      req_tuser  = {it.end_of_message, it.byte_present};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      md_absorb(it);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // Send a message of n random bytes then an end mark, maybe carrying a last byte.
   task automatic send_message(input int n, input bit pause);
      msg_item_type it;
      for (int i = 0; i < n; i++) begin
         it = '{data_byte: 8'($urandom), byte_present: 1'b1, end_of_message: 1'b0};
         send_item(it, pause);
      end
      it = '{data_byte: 8'($urandom), byte_present: 1'($urandom),
             end_of_message: 1'b1};
      send_item(it, pause);
   endtask

   // Receiver: random stalls, long hold-off on request; compare against the oldest digest.
   initial begin
      logic [127:0] want;
      int           wait_cycles;
      rsp_tready = 1'b0;
      fail_count = 0;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready = 1'b0;
            repeat (600) @(negedge clock);
            hold_rsp = 1'b0;
         end
         wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
         rsp_tready = 1'b0;
         repeat (wait_cycles) @(negedge clock);
         rsp_tready = 1'b1;
         @(posedge clock);
         if (rsp_tvalid) begin
            if (digest_queue.size() == 0) begin
               $display("%0t: unexpected digest %h", $time, rsp_tdata);
               fail_count++;
            end else begin
               want = digest_queue.pop_front();
               if (rsp_tdata[63:0] !== want[63:0]) begin
                  $display("%0t: digest_first_half expected %h actual %h",
                           $time, want[63:0], rsp_tdata[63:0]);
                  fail_count++;
               end
               if (rsp_tdata[127:64] !== want[127:64]) begin
                  $display("%0t: digest_second_half expected %h actual %h",
                           $time, want[127:64], rsp_tdata[127:64]);
                  fail_count++;
               end
            end
         end
         @(negedge clock);
      end
   end

   // Directed rows: empty message and "abc" have well-known digests.
   directed_row_type directed_rows [$];

   task automatic add_row(input logic [7:0] b, input bit p, input bit e,
                          input bit known, input logic [127:0] dig);
      directed_row_type row;
      row.item   = '{data_byte: b, byte_present: p, end_of_message: e};
      row.known  = known;
      row.digest = dig;
      directed_rows.push_back(row);
   endtask

   initial begin
      int           n_items;
      int           pick;
      logic [127:0] known_digest;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      hold_rsp   = 1'b0;
      stim_done  = 1'b0;
      md_restart();
      reset = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Empty message; "abc" (bytes 0..15 of each digest, byte 0 lowest).
      add_row(8'h00, 1'b0, 1'b1, 1'b1, 128'h7e42f8ec980980e904b2008fd98c1dd4);
      add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);   // no byte and no end: no effect
      add_row(8'h61, 1'b1, 1'b0, 1'b0, '0);
      add_row(8'h62, 1'b1, 1'b0, 1'b0, '0);
      add_row(8'h63, 1'b1, 1'b1, 1'b1, 128'h727fe1287d3f96d6b04fd23c98500190);
      add_row(8'hff, 1'b1, 1'b0, 1'b0, '0);
      add_row(8'h00, 1'b1, 1'b0, 1'b0, '0);
      add_row(8'hff, 1'b0, 1'b1, 1'b0, '0);   // ignored byte on the end mark
      add_row(8'h80, 1'b1, 1'b1, 1'b0, '0);
      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].item, 1'b1);
         // the digest just queued by the predictor must match the known value
         if (directed_rows[i].known) begin
            known_digest = digest_queue[$];
            if (known_digest !== directed_rows[i].digest) begin
               $display("%0t: known digest expected %h actual %h", $time,
                        directed_rows[i].digest, known_digest);
               fail_count++;
            end
         end
      end

      // Buffer-edge lengths: one and two final blocks.
      send_message(55, 1'b0);
      send_message(56, 1'b1);
      send_message(63, 1'b0);
      send_message(64, 1'b1);

      // Send short messages while the receiver holds off: input stalls on a waiting digest.
      hold_rsp = 1'b1;
      send_message(2, 1'b0);
      send_message(3, 1'b0);
      send_message(1, 1'b0);

      // Pause until every digest has arrived.
      wait (digest_queue.size() == 0);
      repeat (20) @(negedge clock);

      n_items = 0;
      while (n_items < 330) begin
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            send_item('{data_byte: 8'($urandom), byte_present: 1'b0,
                        end_of_message: 1'b0}, 1'b1);
            n_items++;
         end else if (pick < 3) begin
            send_item('{data_byte: 8'($urandom), byte_present: 1'($urandom),
                        end_of_message: 1'($urandom)}, $urandom_range(0, 1));
            n_items++;
         end else begin
            pick = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 140)
                                              : $urandom_range(0, 20);
            send_message(pick, $urandom_range(0, 1));
            n_items += pick + 1;
         end
      end
      stim_done = 1'b1;

      // Drain: wait for every digest (a timeout counts as a failure), then idle before the verdict.
      fork
         wait (digest_queue.size() == 0);
         begin
            repeat (200_000) @(posedge clock);
            fail_count++;
         end
      join_any
      disable fork;
      repeat (300) @(posedge clock);
      if (fail_count == 0 && digest_queue.size() == 0) begin
         $display("tb_md5_message_digest passed");
      end else begin
         $display("tb_md5_message_digest failed");
      end
      $finish;
   end

endmodule
